[hdl/ttc_pkg.sv]
// Shared constants and types for the triangle tile coverage block.
package ttc_pkg;

  localparam int TILE_SIDE_DEF  = 8;
  localparam int COORD_BITS_DEF = 12;
  localparam int MASK_BITS      = 64;
  localparam int NUM_EDGES      = 3;

  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctrl_t;

endpackage

[hdl/ttc_tile_if.sv]
// Tile request channel: three vertices and the tile origin.
interface ttc_tile_if #(
  parameter int COORD_BITS = ttc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x;
  logic signed [COORD_BITS-1:0] v0_y;
  logic signed [COORD_BITS-1:0] v1_x;
  logic signed [COORD_BITS-1:0] v1_y;
  logic signed [COORD_BITS-1:0] v2_x;
  logic signed [COORD_BITS-1:0] v2_y;
  logic signed [COORD_BITS-1:0] tile_x;
  logic signed [COORD_BITS-1:0] tile_y;

  modport source (
    output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, tile_x, tile_y,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, tile_x, tile_y,
    output ready
  );
endinterface

[hdl/ttc_cov_if.sv]
// Coverage result channel: per-pixel mask and any-covered flag.
interface ttc_cov_if;
  import ttc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MASK_BITS-1:0] coverage_mask;
  logic                 any_covered;

  modport source (
    output valid, coverage_mask, any_covered,
    input  ready
  );
  modport sink (
    input  valid, coverage_mask, any_covered,
    output ready
  );
endinterface

[hdl/ttc_edge_setup.sv]
// Edge setup stage: deltas, origin products and top-left flag for one edge.
module ttc_edge_setup #(
  parameter int COORD_BITS = ttc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             advance,
  input  logic signed [COORD_BITS-1:0]     a_x,
  input  logic signed [COORD_BITS-1:0]     a_y,
  input  logic signed [COORD_BITS-1:0]     b_x,
  input  logic signed [COORD_BITS-1:0]     b_y,
  input  logic signed [COORD_BITS-1:0]     t_x,
  input  logic signed [COORD_BITS-1:0]     t_y,
  output logic signed [COORD_BITS:0]       dx_r,
  output logic signed [COORD_BITS:0]       dy_r,
  output logic signed [2*COORD_BITS+1:0]   pa_r,
  output logic signed [2*COORD_BITS+1:0]   pb_r,
  output logic                             top_left_r
);
  import ttc_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dx_nxt;
  logic signed [DW-1:0] dy_nxt;
  logic signed [DW-1:0] ox;
  logic signed [DW-1:0] oy;
  logic signed [PW-1:0] pa_nxt;
  logic signed [PW-1:0] pb_nxt;
  logic                 top_left_nxt;

  always_comb begin
    dx_nxt       = DW'(b_x) - DW'(a_x);
    dy_nxt       = DW'(b_y) - DW'(a_y);
    ox           = DW'(t_x) - DW'(a_x);
    oy           = DW'(t_y) - DW'(a_y);
    pa_nxt       = PW'(dx_nxt) * PW'(oy);
    pb_nxt       = PW'(dy_nxt) * PW'(ox);
    top_left_nxt = (dy_nxt < 0) || ((dy_nxt == 0) && (dx_nxt > 0));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      pa_r       <= pa_nxt;
      pb_r       <= pb_nxt;
      top_left_r <= top_left_nxt;
    end
  end

endmodule

[hdl/ttc_pixel_array.sv]
// Pixel evaluation stage: steps each edge across the tile and registers the mask.
module ttc_pixel_array #(
  parameter int COORD_BITS = ttc_pkg::COORD_BITS_DEF,
  parameter int TILE_SIDE  = ttc_pkg::TILE_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ttc_pkg::pipe_ctrl_t            ctrl,
  input  logic signed [COORD_BITS:0]     dx [ttc_pkg::NUM_EDGES],
  input  logic signed [COORD_BITS:0]     dy [ttc_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+1:0] pa [ttc_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+1:0] pb [ttc_pkg::NUM_EDGES],
  input  logic                           top_left [ttc_pkg::NUM_EDGES],
  output logic [ttc_pkg::MASK_BITS-1:0]  mask_r,
  output logic                           any_r,
  output logic                           valid_r
);
  import ttc_pkg::*;

  localparam int PW = 2 * (COORD_BITS + 1);
  localparam int EW = PW + 2;

  logic [MASK_BITS-1:0] mask_nxt;
  logic                 any_nxt;

  always_comb begin
    logic signed [EW-1:0] e0 [NUM_EDGES];
    logic signed [EW-1:0] val;
    logic                 in_all;
    for (int e = 0; e < NUM_EDGES; e++) begin
      e0[e] = EW'(pa[e]) - EW'(pb[e]);
    end
    mask_nxt = '0;
    for (int r = 0; r < TILE_SIDE; r++) begin
      for (int c = 0; c < TILE_SIDE; c++) begin
        in_all = 1'b1;
        for (int e = 0; e < NUM_EDGES; e++) begin
          val = e0[e] + EW'(r) * EW'(dx[e]) - EW'(c) * EW'(dy[e]);
          if (top_left[e]) begin
            in_all = in_all & (val >= 0);
          end else begin
            in_all = in_all & (val > 0);
          end
        end
        mask_nxt[r*TILE_SIDE+c] = in_all;
      end
    end
    any_nxt = |mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      mask_r <= mask_nxt;
      any_r  <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.advance) begin
      valid_r <= ctrl.valid;
    end
  end

endmodule

[hdl/triangle_tile_coverage_top.sv]
// Top level of the triangle tile coverage block.
// Tests one square pixel tile against one clockwise triangle per transfer using
// edge functions with the top-left fill rule, and returns a coverage mask (bit
// row*TILE_SIDE+col for pixel tile_x+col, tile_y+row) plus an any-covered flag.
// One tile is taken every cycle unless the result channel is stalled; each result
// passes through the edge setup register, then the pixel evaluation register, and
// the pipeline holds while the result channel is stalled. No reset-time sweep.
module triangle_tile_coverage_top #(
  parameter int COORD_BITS = ttc_pkg::COORD_BITS_DEF,
  parameter int TILE_SIDE  = ttc_pkg::TILE_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ttc_tile_if.sink   in_tile,
  ttc_cov_if.source  out_cov
);
  import ttc_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic                 advance;
  logic                 s1_valid_r;
  pipe_ctrl_t           ctrl;

  logic signed [COORD_BITS-1:0] ax [NUM_EDGES];
  logic signed [COORD_BITS-1:0] ay [NUM_EDGES];
  logic signed [COORD_BITS-1:0] bx [NUM_EDGES];
  logic signed [COORD_BITS-1:0] by [NUM_EDGES];

  logic signed [DW-1:0] dx_r [NUM_EDGES];
  logic signed [DW-1:0] dy_r [NUM_EDGES];
  logic signed [PW-1:0] pa_r [NUM_EDGES];
  logic signed [PW-1:0] pb_r [NUM_EDGES];
  logic                 tl_r [NUM_EDGES];

  assign advance       = !out_cov.valid || out_cov.ready;
  assign in_tile.ready = advance;

  // edge order: v1->v2, v0->v1, v2->v0
  assign ax[0] = in_tile.v1_x;
  assign ay[0] = in_tile.v1_y;
  assign bx[0] = in_tile.v2_x;
  assign by[0] = in_tile.v2_y;
  assign ax[1] = in_tile.v0_x;
  assign ay[1] = in_tile.v0_y;
  assign bx[1] = in_tile.v1_x;
  assign by[1] = in_tile.v1_y;
  assign ax[2] = in_tile.v2_x;
  assign ay[2] = in_tile.v2_y;
  assign bx[2] = in_tile.v0_x;
  assign by[2] = in_tile.v0_y;

  for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edge
    ttc_edge_setup #(
      .COORD_BITS (COORD_BITS)
    ) u_setup (
      .clk        (clk),
      .advance    (advance),
      .a_x        (ax[g]),
      .a_y        (ay[g]),
      .b_x        (bx[g]),
      .b_y        (by[g]),
      .t_x        (in_tile.tile_x),
      .t_y        (in_tile.tile_y),
      .dx_r       (dx_r[g]),
      .dy_r       (dy_r[g]),
      .pa_r       (pa_r[g]),
      .pb_r       (pb_r[g]),
      .top_left_r (tl_r[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_tile.valid;
    end
  end

  assign ctrl.advance = advance;
  assign ctrl.valid   = s1_valid_r;

  ttc_pixel_array #(
    .COORD_BITS (COORD_BITS),
    .TILE_SIDE  (TILE_SIDE)
  ) u_pixels (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .dx       (dx_r),
    .dy       (dy_r),
    .pa       (pa_r),
    .pb       (pb_r),
    .top_left (tl_r),
    .mask_r   (out_cov.coverage_mask),
    .any_r    (out_cov.any_covered),
    .valid_r  (out_cov.valid)
  );

endmodule
